FILE: hw/rtl/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg: shared definitions for the paletted 2x2 box downscaler
// Opcodes, field widths and the per-pixel channel record used between the
// lookup lanes and the merge stage.
// ----------------------------------------------------------------------------
package pbd_pkg;

   localparam int unsigned PixelWidth     = 8;
   localparam int unsigned OpcodeWidth    = 2;
   localparam int unsigned TableIdxWidth  = 15;
   localparam int unsigned TableDataWidth = 32;
   localparam int unsigned ChannelWidth   = 8;
   localparam int unsigned SumWidth       = 10;
   localparam int unsigned KeepWidth      = 5;
   localparam int unsigned ColourDepth    = 256;
   localparam int unsigned ColourIdxWidth = $clog2(ColourDepth);
   localparam int unsigned InverseDepth   = 32768;
   localparam int unsigned InverseIdxWidth = $clog2(InverseDepth);
   localparam int unsigned NumLanes       = 4;

   // Bit positions of the three channels inside a colour table entry.
   localparam int unsigned Chan0Lsb = 2;
   localparam int unsigned Chan1Lsb = 13;
   localparam int unsigned Chan2Lsb = 24;

   typedef enum logic [OpcodeWidth-1:0] {
      OP_FILTER        = 2'd0,
      OP_WRITE_COLOUR  = 2'd1,
      OP_WRITE_INVERSE = 2'd2,
      OP_UNUSED        = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [ChannelWidth-1:0] chan2;
      logic [ChannelWidth-1:0] chan1;
      logic [ChannelWidth-1:0] chan0;
   } channels_type;

   // Contents of the stage between the colour lookup and the inverse lookup.
   typedef struct packed {
      logic                       valid;
      opcode_type                 opcode;
      logic [TableIdxWidth-1:0]   table_index;
      logic [PixelWidth-1:0]      table_byte;
   } stage_type;

endpackage

FILE: hw/rtl/pbd_if.sv
// ----------------------------------------------------------------------------
// pbd_if: request and response channels of the downscaler
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pbd_req_if;
   logic                                valid;
   logic                                ready;
   logic [pbd_pkg::OpcodeWidth-1:0]     opcode;
   logic [pbd_pkg::PixelWidth-1:0]      pixel_top_left;
   logic [pbd_pkg::PixelWidth-1:0]      pixel_top_right;
   logic [pbd_pkg::PixelWidth-1:0]      pixel_bottom_left;
   logic [pbd_pkg::PixelWidth-1:0]      pixel_bottom_right;
   logic [pbd_pkg::TableIdxWidth-1:0]   table_index;
   logic [pbd_pkg::TableDataWidth-1:0]  table_data;

   modport source (
      output valid, opcode, pixel_top_left, pixel_top_right,
             pixel_bottom_left, pixel_bottom_right, table_index, table_data,
      input  ready
   );
   modport sink (
      input  valid, opcode, pixel_top_left, pixel_top_right,
             pixel_bottom_left, pixel_bottom_right, table_index, table_data,
      output ready
   );
endinterface

interface pbd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pbd_pkg::PixelWidth-1:0]  out_index;

   modport source (output valid, out_index, input ready);
   modport sink   (input valid, out_index, output ready);
endinterface

FILE: hw/rtl/pbd_lane.sv
// ----------------------------------------------------------------------------
// pbd_lane: one colour lookup lane
// Holds a private copy of the colour table and turns one palette index into
// its three 8-bit channels, read data registered.
// ----------------------------------------------------------------------------
module pbd_lane (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [pbd_pkg::ColourIdxWidth-1:0]   wr_addr,
   input  logic [pbd_pkg::TableDataWidth-1:0]   wr_data,
   input  logic                                 rd_en,
   input  logic [pbd_pkg::PixelWidth-1:0]       rd_addr,
   output pbd_pkg::channels_type                channels
);

   logic [pbd_pkg::TableDataWidth-1:0] colour_table_ff [pbd_pkg::ColourDepth];
   logic [pbd_pkg::TableDataWidth-1:0] entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         colour_table_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         entry_ff <= colour_table_ff[rd_addr];
      end
   end

   assign channels.chan0 = entry_ff[pbd_pkg::Chan0Lsb +: pbd_pkg::ChannelWidth];
   assign channels.chan1 = entry_ff[pbd_pkg::Chan1Lsb +: pbd_pkg::ChannelWidth];
   assign channels.chan2 = entry_ff[pbd_pkg::Chan2Lsb +: pbd_pkg::ChannelWidth];

endmodule

FILE: hw/rtl/pbd_merge.sv
// ----------------------------------------------------------------------------
// pbd_merge: channel merge and inverse palette lookup
// Sums the lanes per channel, forms the 15-bit inverse index from the top
// five bits of each sum and reads the inverse table into the output register.
// ----------------------------------------------------------------------------
module pbd_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pbd_pkg::stage_type                   stage,
   input  pbd_pkg::channels_type                lanes [pbd_pkg::NumLanes],
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [pbd_pkg::PixelWidth-1:0]       rsp_index,
   output logic                                 advance
);

   logic [pbd_pkg::PixelWidth-1:0] inverse_table_ff [pbd_pkg::InverseDepth];
   logic [pbd_pkg::PixelWidth-1:0] out_index_ff;
   logic                           out_valid_ff;
   logic                           out_valid_in;
   logic [pbd_pkg::SumWidth-1:0]   sum0, sum1, sum2;
   logic [pbd_pkg::InverseIdxWidth-1:0] inv_addr;
   logic                           is_filter;
   logic                           is_inv_write;

   // The four values per channel sum to at most 1020, so ten bits never overflow.
   always_comb begin
      sum0 = '0;
      sum1 = '0;
      sum2 = '0;
      for (int i = 0; i < pbd_pkg::NumLanes; i++) begin
         sum0 = sum0 + pbd_pkg::SumWidth'(lanes[i].chan0);
         sum1 = sum1 + pbd_pkg::SumWidth'(lanes[i].chan1);
         sum2 = sum2 + pbd_pkg::SumWidth'(lanes[i].chan2);
      end
   end

   localparam int unsigned KeepLsb = pbd_pkg::SumWidth - pbd_pkg::KeepWidth;

   assign inv_addr = {sum2[KeepLsb +: pbd_pkg::KeepWidth],
                      sum1[KeepLsb +: pbd_pkg::KeepWidth],
                      sum0[KeepLsb +: pbd_pkg::KeepWidth]};

   assign advance      = !out_valid_ff || rsp_ready;
   assign is_filter    = stage.valid && (stage.opcode == pbd_pkg::OP_FILTER);
   assign is_inv_write = stage.valid && (stage.opcode == pbd_pkg::OP_WRITE_INVERSE);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = is_filter;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Writes travel in order with filter reads, so a read never sees a later write.
   always_ff @(posedge clock) begin
      if (advance && is_inv_write) begin
         inverse_table_ff[stage.table_index] <= stage.table_byte;
      end
      if (advance && is_filter) begin
         out_index_ff <= inverse_table_ff[inv_addr];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_index = out_index_ff;

endmodule

FILE: hw/rtl/palette_box_downscale_2x2.sv
// ----------------------------------------------------------------------------
// palette_box_downscale_2x2: 2x2 box-filter downscaler for paletted images
// A filter request passes through the lane and stage registers, then the output
// register. Throughput: one request per cycle while the response side keeps up.
// Reset clears the pipeline valid bits only; both tables stay undefined
// until loaded.
// ----------------------------------------------------------------------------
module palette_box_downscale_2x2 (
   input  logic      clock,
   input  logic      reset,
   pbd_req_if.sink   req_ch,
   pbd_rsp_if.source rsp_ch
);

   // Structure: four identical lookup lanes, one per source pixel of the
   // block. Each lane keeps its own copy of the colour table so that all four
   // lookups happen in the same cycle on single-read memories. Colour table
   // writes go to every lane at once. The lanes register the looked-up entry,
   // and the request's control fields ride along in a matching stage register.
   // The merge stage then adds the channels, builds the inverse index and
   // reads the inverse table into the output register. Inverse table writes
   // are applied in the merge stage so they stay ordered with filter reads.

   pbd_pkg::channels_type lane_channels [pbd_pkg::NumLanes];
   logic [pbd_pkg::PixelWidth-1:0] lane_addr [pbd_pkg::NumLanes];

   pbd_pkg::stage_type stage_ff;
   pbd_pkg::stage_type stage_in;

   logic accept;
   logic merge_advance;
   logic colour_write;
   logic filter_read;

   // The stage register frees up when its content moves on, so a new request
   // is taken even while a finished result waits in the output register, as
   // long as the stage itself is empty.
   assign req_ch.ready = !stage_ff.valid || merge_advance;
   assign accept       = req_ch.valid && req_ch.ready;
   assign colour_write = accept && (req_ch.opcode == pbd_pkg::OP_WRITE_COLOUR);
   assign filter_read  = accept && (req_ch.opcode == pbd_pkg::OP_FILTER);

   assign lane_addr[0] = req_ch.pixel_top_left;
   assign lane_addr[1] = req_ch.pixel_top_right;
   assign lane_addr[2] = req_ch.pixel_bottom_left;
   assign lane_addr[3] = req_ch.pixel_bottom_right;

   for (genvar g = 0; g < pbd_pkg::NumLanes; g++) begin : g_lane
      pbd_lane u_lane (
         .clock    (clock),
         .wr_en    (colour_write),
         .wr_addr  (req_ch.table_index[pbd_pkg::ColourIdxWidth-1:0]),
         .wr_data  (req_ch.table_data),
         .rd_en    (filter_read),
         .rd_addr  (lane_addr[g]),
         .channels (lane_channels[g])
      );
   end

   // Stage register: it loads on acceptance and empties when the merge stage
   // consumes it without a new request arriving behind it.
   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         stage_in.valid       = 1'b1;
         stage_in.opcode      = pbd_pkg::opcode_type'(req_ch.opcode);
         stage_in.table_index = req_ch.table_index;
         stage_in.table_byte  = req_ch.table_data[pbd_pkg::PixelWidth-1:0];
      end else if (merge_advance) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.opcode      <= stage_in.opcode;
      stage_ff.table_index <= stage_in.table_index;
      stage_ff.table_byte  <= stage_in.table_byte;
   end

   // The merge stage owns the output register and tells us when it can take
   // the stage content; an unused opcode simply drains without a result.
   pbd_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage_ff),
      .lanes     (lane_channels),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_index (rsp_ch.out_index),
      .advance   (merge_advance)
   );

endmodule

FILE: tb/palette_box_downscale_2x2_monitor.sv
// ----------------------------------------------------------------------------
// palette_box_downscale_2x2_monitor: result prediction for the 2x2 downscaler
// Watches both channels. Keeps its own copy of the two lookup tables, predicts
// the output palette index of every filter request, and compares each
// response with the oldest prediction.
// ----------------------------------------------------------------------------
module palette_box_downscale_2x2_monitor (
   input  logic clock,
   input  logic reset,
   pbd_req_if   req_ch,
   pbd_rsp_if   rsp_ch,
   output int   mismatch_count,
   output int   outstanding_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ReportLimit = 10;

   logic [pbd_pkg::TableDataWidth-1:0] colour_shadow [pbd_pkg::ColourDepth];
   logic [pbd_pkg::PixelWidth-1:0]     inverse_shadow [pbd_pkg::InverseDepth];
   logic [pbd_pkg::PixelWidth-1:0]     expected_out_index [$];
   int                                 fail_total;

   // Sums each channel over the four pixels, keeps the top bits of each sum
   // and looks the packed result up in the inverse table.
   function automatic logic [pbd_pkg::PixelWidth-1:0] averaged_index(
      input logic [pbd_pkg::NumLanes-1:0][pbd_pkg::PixelWidth-1:0] block
   );
      logic [pbd_pkg::SumWidth-1:0]       red_sum, green_sum, blue_sum;
      logic [pbd_pkg::TableDataWidth-1:0] entry;
      red_sum   = '0;
      green_sum = '0;
      blue_sum  = '0;
      for (int lane = 0; lane < pbd_pkg::NumLanes; lane++) begin
         entry     = colour_shadow[block[lane]];
         red_sum   = red_sum +
                     pbd_pkg::SumWidth'(entry[pbd_pkg::Chan0Lsb +: pbd_pkg::ChannelWidth]);
         green_sum = green_sum +
                     pbd_pkg::SumWidth'(entry[pbd_pkg::Chan1Lsb +: pbd_pkg::ChannelWidth]);
         blue_sum  = blue_sum +
                     pbd_pkg::SumWidth'(entry[pbd_pkg::Chan2Lsb +: pbd_pkg::ChannelWidth]);
      end
      return inverse_shadow[{blue_sum[pbd_pkg::SumWidth-1 -: pbd_pkg::KeepWidth],
                             green_sum[pbd_pkg::SumWidth-1 -: pbd_pkg::KeepWidth],
                             red_sum[pbd_pkg::SumWidth-1 -: pbd_pkg::KeepWidth]}];
   endfunction

   always @(posedge clock) begin
      logic [pbd_pkg::PixelWidth-1:0] want;
      if (reset) begin
         expected_out_index.delete();
         fail_total        = 0;
         mismatch_count    <= 0;
         outstanding_count <= 0;
      end else begin
         // Responses are handled first: with a pipelined block a response
         // can never belong to a request taken at the same edge.
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_out_index.size() == 0) begin
               if (fail_total < ReportLimit)
                  $display("%t: response %0d with no filter request pending",
                           $realtime, rsp_ch.out_index);
               fail_total++;
            end else begin
               want = expected_out_index.pop_front();
               if (rsp_ch.out_index !== want) begin
                  if (fail_total < ReportLimit)
                     $display("%t: out_index mismatch, expected %0d, got %0d",
                              $realtime, want, rsp_ch.out_index);
                  fail_total++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            case (pbd_pkg::opcode_type'(req_ch.opcode))
               pbd_pkg::OP_FILTER: begin
                  expected_out_index.push_back(averaged_index(
                     {req_ch.pixel_bottom_right, req_ch.pixel_bottom_left,
                      req_ch.pixel_top_right, req_ch.pixel_top_left}));
               end
               pbd_pkg::OP_WRITE_COLOUR: begin
                  colour_shadow[req_ch.table_index[pbd_pkg::ColourIdxWidth-1:0]] =
                     req_ch.table_data;
               end
               pbd_pkg::OP_WRITE_INVERSE: begin
                  inverse_shadow[req_ch.table_index] =
                     req_ch.table_data[pbd_pkg::PixelWidth-1:0];
               end
               default: ;
            endcase
         end
         mismatch_count    <= fail_total;
         outstanding_count <= expected_out_index.size();
      end
   end

endmodule

FILE: tb/palette_box_downscale_2x2_test.sv
// ----------------------------------------------------------------------------
// palette_box_downscale_2x2_test: top level of the downscaler testbench
// Loads the colour and inverse tables, sends 2x2 filter requests built only
// from loaded entries, and lets the monitor check every output index. Both
// channels stall at random, with stretches of full-rate traffic.
// ----------------------------------------------------------------------------
module palette_box_downscale_2x2_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RandomRequests = 1650;
   localparam int unsigned WatchdogLimit  = 1000;
   localparam int unsigned DrainCycles    = 10;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   outstanding_count;
   int   stall_cycles;

   pbd_req_if req_if ();
   pbd_rsp_if rsp_if ();

   palette_box_downscale_2x2 u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   palette_box_downscale_2x2_monitor u_monitor (
      .clock             (clock),
      .reset             (reset),
      .req_ch            (req_if),
      .rsp_ch            (rsp_if),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   // The stimulus side keeps its own view of what has been loaded. The tables
   // come out of reset undefined, so a filter request may only touch colour
   // entries that were written, and it may only land on an inverse entry that
   // was written. The colour copy is needed to work out where it lands.
   logic [pbd_pkg::TableDataWidth-1:0] colour_copy [pbd_pkg::ColourDepth];
   bit                                 colour_known [pbd_pkg::ColourDepth];
   bit                                 inverse_known [pbd_pkg::InverseDepth];
   logic [pbd_pkg::PixelWidth-1:0]     colour_loaded_list [$];

   int filter_total;
   int colour_total;
   int inverse_total;
   int unused_total;
   int inverse_entries;

   // Sender pacing: a run of requests is either full rate or gapped.
   bit src_quiet;
   int src_run_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A random table index over the full 15-bit range.
   function automatic logic [pbd_pkg::TableIdxWidth-1:0] random_index();
      return pbd_pkg::TableIdxWidth'($urandom());
   endfunction

   // Inverse table address that a block of four pixels will read.
   function automatic logic [pbd_pkg::InverseIdxWidth-1:0] inverse_address(
      input logic [pbd_pkg::NumLanes-1:0][pbd_pkg::PixelWidth-1:0] block
   );
      logic [pbd_pkg::SumWidth-1:0]       sum0, sum1, sum2;
      logic [pbd_pkg::TableDataWidth-1:0] entry;
      sum0 = '0;
      sum1 = '0;
      sum2 = '0;
      for (int lane = 0; lane < pbd_pkg::NumLanes; lane++) begin
         entry = colour_copy[block[lane]];
         sum0  = sum0 +
                 pbd_pkg::SumWidth'(entry[pbd_pkg::Chan0Lsb +: pbd_pkg::ChannelWidth]);
         sum1  = sum1 +
                 pbd_pkg::SumWidth'(entry[pbd_pkg::Chan1Lsb +: pbd_pkg::ChannelWidth]);
         sum2  = sum2 +
                 pbd_pkg::SumWidth'(entry[pbd_pkg::Chan2Lsb +: pbd_pkg::ChannelWidth]);
      end
      return {sum2[pbd_pkg::SumWidth-1 -: pbd_pkg::KeepWidth],
              sum1[pbd_pkg::SumWidth-1 -: pbd_pkg::KeepWidth],
              sum0[pbd_pkg::SumWidth-1 -: pbd_pkg::KeepWidth]};
   endfunction

   // Presents one request and holds it until the block takes it. When no gap
   // is drawn, valid simply stays high and only the payload changes, so valid
   // is never lowered and raised again at the same edge.
   task automatic send_request(
      input pbd_pkg::opcode_type                                    op,
      input logic [pbd_pkg::NumLanes-1:0][pbd_pkg::PixelWidth-1:0] block,
      input logic [pbd_pkg::TableIdxWidth-1:0]                      tidx,
      input logic [pbd_pkg::TableDataWidth-1:0]                     tdata
   );
      int gap;
      if (src_run_left == 0) begin
         src_quiet    = ($urandom_range(0, 3) == 0);
         src_run_left = $urandom_range(10, 60);
      end
      src_run_left--;
      gap = src_quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid              <= 1'b1;
      req_if.opcode             <= op;
      req_if.pixel_top_left     <= block[0];
      req_if.pixel_top_right    <= block[1];
      req_if.pixel_bottom_left  <= block[2];
      req_if.pixel_bottom_right <= block[3];
      req_if.table_index        <= tidx;
      req_if.table_data         <= tdata;
      do @(posedge clock); while (!req_if.ready);

      // The request is in; bring the stimulus view of the tables up to date.
      case (op)
         pbd_pkg::OP_FILTER: filter_total++;
         pbd_pkg::OP_WRITE_COLOUR: begin
            colour_total++;
            colour_copy[tidx[pbd_pkg::ColourIdxWidth-1:0]] = tdata;
            if (!colour_known[tidx[pbd_pkg::ColourIdxWidth-1:0]]) begin
               colour_known[tidx[pbd_pkg::ColourIdxWidth-1:0]] = 1'b1;
               colour_loaded_list.push_back(tidx[pbd_pkg::ColourIdxWidth-1:0]);
            end
         end
         pbd_pkg::OP_WRITE_INVERSE: begin
            inverse_total++;
            if (!inverse_known[tidx]) begin
               inverse_known[tidx] = 1'b1;
               inverse_entries++;
            end
         end
         default: unused_total++;
      endcase
   endtask

   // Load requests carry random pixel fields, which the block must ignore.
   task automatic load_colour(
      input logic [pbd_pkg::TableIdxWidth-1:0]  tidx,
      input logic [pbd_pkg::TableDataWidth-1:0] tdata
   );
      send_request(pbd_pkg::OP_WRITE_COLOUR, $urandom(), tidx, tdata);
   endtask

   task automatic load_inverse(
      input logic [pbd_pkg::TableIdxWidth-1:0]  tidx,
      input logic [pbd_pkg::TableDataWidth-1:0] tdata
   );
      send_request(pbd_pkg::OP_WRITE_INVERSE, $urandom(), tidx, tdata);
   endtask

   // A filter request, preceded by an inverse load when the block would land
   // on an entry that was never written. Table fields are random noise here.
   task automatic filter_block(
      input logic [pbd_pkg::NumLanes-1:0][pbd_pkg::PixelWidth-1:0] block
   );
      logic [pbd_pkg::InverseIdxWidth-1:0] addr;
      addr = inverse_address(block);
      if (!inverse_known[addr])
         load_inverse(addr, $urandom());
      send_request(pbd_pkg::OP_FILTER, block, random_index(), $urandom());
   endtask

   function automatic logic [pbd_pkg::PixelWidth-1:0] loaded_pixel();
      return colour_loaded_list[$urandom_range(0, colour_loaded_list.size() - 1)];
   endfunction

   // Colour data: mostly random, sometimes one of the corner patterns (all
   // clear, all set, only the three channels set, only the dropped bits set).
   function automatic logic [pbd_pkg::TableDataWidth-1:0] colour_value();
      case ($urandom_range(0, 15))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'hff1f_e3fc;
         3:       return 32'h00e0_1c03;
         default: return $urandom();
      endcase
   endfunction

   // Response side: before each response the receiver holds ready low for a
   // random number of cycles, except during full-rate stretches.
   initial begin
      int  gap;
      int  run_left;
      bit  quiet;
      run_left = 0;
      quiet    = 1'b0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (run_left == 0) begin
            quiet    = ($urandom_range(0, 3) == 0);
            run_left = $urandom_range(10, 60);
         end
         run_left--;
         gap = quiet ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // The watchdog counts edges at which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WatchdogLimit) begin
            $display("Timeout: no request or response moved for %0d cycles", stall_cycles);
            $display("palette_box_downscale_2x2_test NOT OK");
            $finish;
         end
      end
   end

   initial begin
      logic [pbd_pkg::NumLanes-1:0][pbd_pkg::PixelWidth-1:0] block;
      int                                                    pick;
      logic [pbd_pkg::PixelWidth-1:0]                        pix;

      src_quiet       = 1'b0;
      src_run_left    = 0;
      filter_total    = 0;
      colour_total    = 0;
      inverse_total   = 0;
      unused_total    = 0;
      inverse_entries = 0;

      reset                     = 1'b1;
      req_if.valid              <= 1'b0;
      req_if.opcode             <= pbd_pkg::OP_FILTER;
      req_if.pixel_top_left     <= '0;
      req_if.pixel_top_right    <= '0;
      req_if.pixel_bottom_left  <= '0;
      req_if.pixel_bottom_right <= '0;
      req_if.table_index        <= '0;
      req_if.table_data         <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- Directed part ----
      // Colour entries at the corners. The load at 15'h7f01 checks that only
      // the low byte of the index selects the colour entry, so it lands on 1.
      load_colour(15'h0000, 32'h0000_0000);
      load_colour(15'h00ff, 32'hffff_ffff);
      load_colour(15'h7f01, 32'hff1f_e3fc);
      load_colour(15'h0002, 32'h00e0_1c03);
      load_colour(15'h0003, 32'h5a5a_5a5a);

      // Inverse entries at both ends; only the low byte of the data counts.
      load_inverse(15'h0000, 32'hffff_ff00);
      load_inverse(15'h7fff, 32'hffff_ffff);

      // All-zero block, all-full block, a block that only sets the channel
      // bits (must match the all-full one), and one that only sets the bits
      // the filter drops (must match the all-zero one).
      filter_block({8'd0, 8'd0, 8'd0, 8'd0});
      filter_block({8'd255, 8'd255, 8'd255, 8'd255});
      filter_block({8'd1, 8'd1, 8'd1, 8'd1});
      filter_block({8'd2, 8'd2, 8'd2, 8'd2});
      filter_block({8'd2, 8'd1, 8'd255, 8'd0});
      filter_block({8'd1, 8'd0, 8'd255, 8'd3});

      // The unused opcode must not write anything, even with load-like fields.
      send_request(pbd_pkg::OP_UNUSED, 32'hffff_ffff, 15'h0000, 32'hffff_ffff);
      send_request(pbd_pkg::OP_UNUSED, $urandom(), random_index(), $urandom());
      filter_block({8'd0, 8'd0, 8'd0, 8'd0});

      // A table write directly followed by a filter that reads the new value.
      load_colour(15'h0000, 32'hffff_ffff);
      filter_block({8'd0, 8'd0, 8'd0, 8'd0});
      load_inverse(15'h7fff, 32'h0000_0000);
      filter_block({8'd255, 8'd255, 8'd255, 8'd255});
      load_colour(15'h0000, 32'h0000_0000);
      filter_block({8'd0, 8'd255, 8'd0, 8'd255});

      // ---- Random part ----
      // Mostly filter blocks over loaded entries, with loads mixed in so the
      // tables keep changing under traffic, plus some unused-opcode noise.
      while (filter_total + colour_total + inverse_total + unused_total < RandomRequests)
      begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            load_colour(random_index(), colour_value());
         end else if (pick < 14) begin
            load_inverse(random_index(), $urandom());
         end else if (pick < 18) begin
            send_request(pbd_pkg::OP_UNUSED, $urandom(), random_index(), $urandom());
         end else if (pick < 32) begin
            // A uniform block averages to the pixel's own colour.
            pix = loaded_pixel();
            filter_block({pix, pix, pix, pix});
         end else begin
            for (int lane = 0; lane < pbd_pkg::NumLanes; lane++)
               block[lane] = loaded_pixel();
            filter_block(block);
         end
      end
      req_if.valid <= 1'b0;

      // Wait for the last responses, then give the block time to show any
      // response that it should not produce.
      do @(posedge clock); while (outstanding_count != 0);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d filter blocks, %0d colour loads, %0d inverse loads,",
               filter_total, colour_total, inverse_total);
      $display("%0d unused-opcode requests; colour entries in use: %0d of %0d;",
               unused_total, colour_loaded_list.size(), pbd_pkg::ColourDepth);
      $display("inverse entries written: %0d.", inverse_entries);
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("palette_box_downscale_2x2_test OK");
      end else begin
         $display("%0d failures, %0d responses missing", mismatch_count, outstanding_count);
         $display("palette_box_downscale_2x2_test NOT OK");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/pbd_pkg.sv
hw/rtl/pbd_if.sv
hw/rtl/pbd_lane.sv
hw/rtl/pbd_merge.sv
hw/rtl/palette_box_downscale_2x2.sv
tb/palette_box_downscale_2x2_monitor.sv
tb/palette_box_downscale_2x2_test.sv
